// ----- rtl/bba_pkg.sv -----
// Shared types, constants and helpers of the bitmap block allocator.
package bba_pkg;

  localparam int MAP_WORDS    = 4;
  localparam int WORD_W       = 32;
  localparam int BIT_IDX_W    = $clog2(WORD_W);
  localparam int NUM_W        = 8;
  localparam int NUMBER_LIMIT = (1 << NUM_W) - 1;
  localparam int TOTAL_BLOCKS = MAP_WORDS * WORD_W;
  localparam int LAST_BLOCK   = (TOTAL_BLOCKS > NUMBER_LIMIT) ? NUMBER_LIMIT : TOTAL_BLOCKS;
  // Words that hold at least one addressable block; any words above stay free forever.
  localparam int USED_WORDS   = (LAST_BLOCK + WORD_W - 1) / WORD_W;
  localparam int WORD_IDX_W   = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
  localparam int STATUS_W     = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic start;
    logic advance;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_free;
    logic hit;
    logic last_word;
    logic out_free;
  } dp_status_t;

  // Bits of map word w that stand for a block number inside the addressable range.
  function automatic logic [WORD_W-1:0] word_mask(input logic [WORD_IDX_W-1:0] w);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      m[b] = ((int'(w) * WORD_W + b + 1) <= LAST_BLOCK);
    end
    return m;
  endfunction

endpackage

// ----- rtl/bba_if.sv -----
// Request and response channel interfaces of the bitmap block allocator.
interface bba_req_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [NUM_W-1:0] block_number;

  modport source (output valid, operation, block_number, input ready);
  modport sink   (input valid, operation, block_number, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NUM_W-1:0]    granted_number;

  modport source (output valid, status, granted_number, input ready);
  modport sink   (input valid, status, granted_number, output ready);
endinterface

// ----- rtl/bba_ctrl.sv -----
// Controller state machine of the bitmap block allocator.
module bba_ctrl import bba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_e;

  state_e state_q, state_d;
  logic   done;

  always_comb begin
    done          = status_i.op_free || status_i.hit || status_i.last_word;
    cmd_o.start   = 1'b0;
    cmd_o.advance = 1'b0;
    cmd_o.commit  = 1'b0;
    state_d       = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_BUSY;
        end
      end
      S_BUSY: begin
        if (!done) begin
          cmd_o.advance = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == S_BUSY))
    else $error("start did not enter busy");

  a_commit_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (state_q == S_IDLE))
    else $error("commit did not return to idle");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.start, cmd_o.advance, cmd_o.commit}) <= 1)
    else $error("more than one command at once");

endmodule

// ----- rtl/bba_datapath.sv -----
// Datapath of the bitmap block allocator: usage map, scan counter and result register.
module bba_datapath import bba_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  logic                req_operation_i,
  input  logic [NUM_W-1:0]    req_block_number_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic [STATUS_W-1:0] rsp_status_o,
  output logic [NUM_W-1:0]    rsp_granted_number_o
);

  logic [WORD_W-1:0]     map_q [USED_WORDS];
  logic                  op_q;
  logic [NUM_W-1:0]      num_q;
  logic [WORD_IDX_W-1:0] idx_q;
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [NUM_W-1:0]      out_num_q;

  logic [NUM_W-1:0]      free_idx;
  logic [WORD_IDX_W-1:0] free_word;
  logic [BIT_IDX_W-1:0]  free_bit;
  logic                  in_range;
  logic [WORD_IDX_W-1:0] rd_addr;
  logic [WORD_W-1:0]     rd_word;
  logic [WORD_W-1:0]     avail;
  logic                  hit;
  logic [BIT_IDX_W-1:0]  first_bit;
  logic [NUM_W-1:0]      grant_num;
  logic                  op_free;

  assign op_free   = (op_q == OP_FREE);
  assign free_idx  = num_q - NUM_W'(1);
  assign free_word = free_idx[BIT_IDX_W +: WORD_IDX_W];
  assign free_bit  = free_idx[BIT_IDX_W-1:0];
  assign in_range  = (num_q != '0) && (num_q <= NUM_W'(LAST_BLOCK));
  assign rd_addr   = op_free ? free_word : idx_q;
  assign rd_word   = map_q[rd_addr];
  assign avail     = ~rd_word & word_mask(idx_q);
  assign hit       = (avail != '0);

  always_comb begin
    first_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        first_bit = BIT_IDX_W'(b);
      end
    end
  end

  assign grant_num = NUM_W'({idx_q, first_bit}) + NUM_W'(1);

  assign status_o.op_free   = op_free;
  assign status_o.hit       = hit;
  assign status_o.last_word = (idx_q == WORD_IDX_W'(USED_WORDS - 1));
  assign status_o.out_free  = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= req_operation_i;
      num_q <= req_block_number_i;
      idx_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + WORD_IDX_W'(1);
    end
    if (cmd_i.commit) begin
      if (op_free) begin
        out_num_q    <= '0;
        out_status_q <= in_range ? ST_OK : ST_RANGE;
      end else begin
        out_num_q    <= hit ? grant_num : '0;
        out_status_q <= hit ? ST_OK : ST_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < USED_WORDS; w++) begin
        map_q[w] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (op_free) begin
        if (in_range) begin
          map_q[free_word][free_bit] <= 1'b0;
        end
      end else if (hit) begin
        map_q[idx_q][first_bit] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o          = out_valid_q;
  assign rsp_status_o         = out_status_q;
  assign rsp_granted_number_o = out_num_q;

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || rsp_ready_i))
    else $error("result overwritten before it was taken");

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("commit without result beat");

  a_grant_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !op_free) |=> ((out_status_q == ST_OK) == (out_num_q != '0)))
    else $error("granted number disagrees with status");

endmodule

// ----- rtl/bitmap_block_allocator.sv -----
// Top level of the bitmap block allocator.
// First-fit block allocator over a usage bitmap of MAP_WORDS 32-bit words, all free after
// reset; bit b of word w is block w*32+b+1, and only blocks 1 to 128 are addressable. A
// request beat with operation 0 allocates the lowest free block and answers its number,
// or map full; operation 1 frees the given block, answering out of range for 0 or a
// number past the last block. Each request gives exactly one response beat. An allocate
// scans the map words in order from word 0 (4 map words in use here) and stops at the word
// holding the first free bit, since the datapath reads one map word per cycle through its
// single read port. The next request is accepted once the previous one has its result in
// the output register.
module bitmap_block_allocator import bba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bba_req_if.sink     req_i,
  bba_rsp_if.source   rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  bba_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (dp_status),
    .req_operation_i      (req_i.operation),
    .req_block_number_i   (req_i.block_number),
    .rsp_valid_o          (rsp_o.valid),
    .rsp_ready_i          (rsp_o.ready),
    .rsp_status_o         (rsp_o.status),
    .rsp_granted_number_o (rsp_o.granted_number)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the bitmap block allocator: directed and random request traffic.
module tb_top import bba_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct packed {
    status_e          status;
    logic [NUM_W-1:0] granted;
  } grant_t;

  class grant_tracker;
    bit [WORD_W-1:0] usage_words [MAP_WORDS];
    grant_t pending_grants [$];
    int errors, n_checked, n_alloc, n_free, n_full, n_range;

    function new();
      foreach (usage_words[w]) usage_words[w] = '0;
    endfunction

    function grant_t predict_grant(op_e op, logic [NUM_W-1:0] num);
      grant_t g;
      int idx;
      g.status  = ST_OK;
      g.granted = '0;
      if (op == OP_ALLOC) begin
        n_alloc++;
        g.status = ST_FULL;
        for (idx = 0; idx < LAST_BLOCK; idx++) begin
          if (!usage_words[idx / WORD_W][idx % WORD_W]) begin
            usage_words[idx / WORD_W][idx % WORD_W] = 1'b1;
            g.status  = ST_OK;
            g.granted = NUM_W'(idx + 1);
            break;
          end
        end
        if (g.status == ST_FULL) n_full++;
      end else begin
        n_free++;
        if (num == 0 || int'(num) > LAST_BLOCK) begin
          g.status = ST_RANGE;
          n_range++;
        end else begin
          idx = int'(num) - 1;
          usage_words[idx / WORD_W][idx % WORD_W] = 1'b0;
        end
      end
      return g;
    endfunction

    function void note_request(op_e op, logic [NUM_W-1:0] num);
      pending_grants.push_back(predict_grant(op, num));
    endfunction

    function void check_grant(logic [STATUS_W-1:0] status, logic [NUM_W-1:0] granted);
      grant_t g;
      n_checked++;
      if (pending_grants.size() == 0) begin
        $error("response beat with no request outstanding: status %0d granted %0d",
               status, granted);
        errors++;
        return;
      end
      g = pending_grants.pop_front();
      if (status !== g.status) begin
        $error("status: expected %0d, actual %0d", g.status, status);
        errors++;
      end
      if (granted !== g.granted) begin
        $error("granted_number: expected %0d, actual %0d", g.granted, granted);
        errors++;
      end
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  grant_tracker tracker = new();
  bit calm;
  bit hold_rsp_req;
  int sent;

  bitmap_block_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic send_req(op_e op, logic [NUM_W-1:0] num);
    if (!calm) begin
      while ($urandom_range(0, 99) < 21) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid        <= 1'b1;
    req_if.operation    <= op;
    req_if.block_number <= num;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(op, num);
    sent++;
  endtask

  function automatic logic [NUM_W-1:0] pick_free_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 12) return NUM_W'($urandom_range(LAST_BLOCK + 1, NUMBER_LIMIT));
    return NUM_W'($urandom_range(1, LAST_BLOCK));
  endfunction

  task automatic run_phase(int len, int alloc_pct);
    for (int i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < alloc_pct)
        send_req(OP_ALLOC, NUM_W'($urandom_range(0, NUMBER_LIMIT)));
      else
        send_req(OP_FREE, pick_free_number());
      if (sent == 400) hold_rsp_req = 1'b1;
    end
  endtask

  // Stimulus
  initial begin
    int kind;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.operation    = OP_ALLOC;
    req_if.block_number = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // range checks, free of a free block, first-fit reuse
    send_req(OP_FREE, 8'd0);
    send_req(OP_FREE, 8'd255);
    send_req(OP_FREE, NUM_W'(LAST_BLOCK + 1));
    send_req(OP_FREE, NUM_W'(LAST_BLOCK));
    send_req(OP_FREE, 8'd1);
    send_req(OP_ALLOC, 8'hff);
    send_req(OP_ALLOC, 8'h00);
    send_req(OP_ALLOC, 8'h55);
    send_req(OP_ALLOC, 8'haa);
    send_req(OP_FREE, 8'd2);
    send_req(OP_ALLOC, 8'd0);
    send_req(OP_FREE, 8'd1);
    send_req(OP_FREE, 8'd3);
    send_req(OP_ALLOC, 8'd0);
    send_req(OP_ALLOC, 8'd0);
    send_req(OP_FREE, 8'd4);
    send_req(OP_FREE, 8'd4);
    send_req(OP_ALLOC, 8'd0);

    // fill past full, then free the top block and take it again
    run_phase(LAST_BLOCK + 8, 100);
    send_req(OP_FREE, NUM_W'(LAST_BLOCK));
    send_req(OP_ALLOC, 8'd0);
    send_req(OP_ALLOC, 8'd0);

    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 2);
      if (sent > 650 && sent < 900) calm = 1'b1;
      else calm = 1'b0;
      case (kind)
        0: begin
          run_phase($urandom_range(40, 160), 92);
        end
        1: begin
          run_phase($urandom_range(40, 160), 20);
        end
        default: begin
          run_phase($urandom_range(40, 160), 55);
        end
      endcase
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.pending() != 0) tracker.errors++;

    $display("Checked %0d responses from %0d requests: %0d allocates (%0d full), %0d frees",
             tracker.n_checked, sent, tracker.n_alloc, tracker.n_full, tracker.n_free);
    $display("  %0d frees out of range, including numbers past the %0d-block map",
             tracker.n_range, LAST_BLOCK);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Response side: random stalls, one long hold-off, calm stretch
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rsp_req && !hold_done) begin
        hold_left = RSP_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= calm || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      tracker.check_grant(rsp_if.status, rsp_if.granted_number);
  end

  // Watchdog on cycles without any beat
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule

// ----- bitmap_block_allocator.f -----
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_ctrl.sv
rtl/bba_datapath.sv
rtl/bitmap_block_allocator.sv
tb/sv/tb_top.sv
